@@ sv/lcua_pkg.sv @@
// Shared types and constants for the load-cell under-thrust abort monitor.
// Used by every module of the block; depends on nothing.
package lcua_pkg;

   localparam int CHANNELS_DEF = 4;
   localparam int IN_CH        = 4;
   localparam int LOAD_W       = 24;
   localparam int TIME_W       = 32;
   localparam int MIN_W        = 28;
   localparam int CSR_W        = 32;
   localparam int CSR_IDX_W    = 2;
   localparam int KIND_W       = 2;
   localparam int REQ_DATA_W   = 136;
   localparam int RSP_DATA_W   = 8;

   localparam logic signed [MIN_W-1:0] MIN_THRUST_RST = 28'sd100;
   localparam logic [TIME_W-1:0]       ABORT_TIME_RST = 32'd500;
   localparam logic [TIME_W-1:0]       ARM_DELAY_RST  = 32'd2000;

   typedef enum logic [KIND_W-1:0] {
      KIND_CHECK = 2'd0,
      KIND_START = 2'd1,
      KIND_STOP  = 2'd2
   } kind_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MIN_THRUST = 2'd0,
      CSR_ABORT_TIME = 2'd1,
      CSR_ARM_DELAY  = 2'd2
   } csr_idx_type;

   typedef struct packed {
      logic signed [MIN_W-1:0] min_thrust;
      logic [TIME_W-1:0]       abort_time_ms;
      logic [TIME_W-1:0]       arm_delay_ms;
   } cfg_type;

   typedef struct packed {
      logic under_thrust;
      logic active;
      logic abort;
   } result_type;

endpackage

@@ sv/lcua_csr.sv @@
// Configuration registers of the under-thrust monitor.
// Depends on lcua_pkg for the register index codes and reset values.
module lcua_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [lcua_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [lcua_pkg::CSR_W-1:0]          csr_wdata,
   output lcua_pkg::cfg_type                   cfg
);

   lcua_pkg::cfg_type cfg_ff;
   lcua_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (lcua_pkg::csr_idx_type'(csr_index))
            lcua_pkg::CSR_MIN_THRUST: cfg_in.min_thrust    = csr_wdata[lcua_pkg::MIN_W-1:0];
            lcua_pkg::CSR_ABORT_TIME: cfg_in.abort_time_ms = csr_wdata[lcua_pkg::TIME_W-1:0];
            lcua_pkg::CSR_ARM_DELAY:  cfg_in.arm_delay_ms  = csr_wdata[lcua_pkg::TIME_W-1:0];
            default:                  cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.min_thrust    <= lcua_pkg::MIN_THRUST_RST;
         cfg_ff.abort_time_ms <= lcua_pkg::ABORT_TIME_RST;
         cfg_ff.arm_delay_ms  <= lcua_pkg::ARM_DELAY_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

@@ sv/lcua_sum.sv @@
// Sum over all channels of reading minus baseline.
// Depends on lcua_pkg for the reading width.
module lcua_sum #(
   parameter int CHANNELS = lcua_pkg::CHANNELS_DEF,
   localparam int SUM_W   = lcua_pkg::LOAD_W + 1 + $clog2(CHANNELS)
) (
   input  logic [CHANNELS-1:0][lcua_pkg::LOAD_W-1:0] loads,
   input  logic [CHANNELS-1:0][lcua_pkg::LOAD_W-1:0] baselines,
   output logic signed [SUM_W-1:0]                   sum
);

   logic signed [lcua_pkg::LOAD_W:0] diff [CHANNELS];

   always_comb begin
      for (int ch = 0; ch < CHANNELS; ch++) begin
         diff[ch] = $signed({loads[ch][lcua_pkg::LOAD_W-1], loads[ch]})
                  - $signed({baselines[ch][lcua_pkg::LOAD_W-1], baselines[ch]});
      end
   end

   always_comb begin
      sum = '0;
      for (int ch = 0; ch < CHANNELS; ch++) begin
         sum = sum + SUM_W'(diff[ch]);
      end
   end

endmodule

@@ sv/lcua_mon.sv @@
// Monitor state (baselines, arm and persistence timers) and per-word decision.
// Depends on lcua_pkg and lcua_sum.
module lcua_mon #(
   parameter int CHANNELS = lcua_pkg::CHANNELS_DEF
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     step,
   input  logic [lcua_pkg::KIND_W-1:0]              kind,
   input  logic [lcua_pkg::TIME_W-1:0]              now_ms,
   input  logic [CHANNELS-1:0][lcua_pkg::LOAD_W-1:0] loads,
   input  logic                                     hotfire,
   input  lcua_pkg::cfg_type                        cfg,
   output lcua_pkg::result_type                     result
);

   localparam int SUM_W = lcua_pkg::LOAD_W + 1 + $clog2(CHANNELS);
   localparam int CMP_W = (SUM_W > lcua_pkg::MIN_W) ? SUM_W : lcua_pkg::MIN_W;

   logic [CHANNELS-1:0][lcua_pkg::LOAD_W-1:0] baseline_ff, baseline_in;
   logic                          armed_ff, armed_in;
   logic [lcua_pkg::TIME_W-1:0]   arm_time_ff, arm_time_in;
   logic                          bad_valid_ff, bad_valid_in;
   logic [lcua_pkg::TIME_W-1:0]   bad_since_ff, bad_since_in;

   logic signed [SUM_W-1:0]       sum;
   logic [lcua_pkg::TIME_W-1:0]   since_eff;
   logic                          is_check;
   logic                          is_start;
   logic                          is_stop;
   logic                          under;

   lcua_sum #(
      .CHANNELS (CHANNELS)
   ) u_sum (
      .loads     (loads),
      .baselines (baseline_ff),
      .sum       (sum)
   );

   always_comb begin
      is_check = 1'b0;
      is_start = 1'b0;
      is_stop  = 1'b0;
      case (lcua_pkg::kind_type'(kind))
         lcua_pkg::KIND_CHECK: is_check = 1'b1;
         lcua_pkg::KIND_START: is_start = hotfire;
         lcua_pkg::KIND_STOP:  is_stop  = 1'b1;
         default:              is_check = 1'b0;
      endcase
   end

   always_comb begin
      baseline_in  = baseline_ff;
      armed_in     = armed_ff;
      arm_time_in  = arm_time_ff;
      bad_valid_in = bad_valid_ff;
      bad_since_in = bad_since_ff;
      result       = '0;

      if (is_start) begin
         baseline_in  = loads;
         armed_in     = 1'b1;
         arm_time_in  = now_ms;
         bad_valid_in = 1'b0;
         bad_since_in = '0;
      end else if (is_stop) begin
         armed_in = 1'b0;
      end

      result.active = armed_in && ((now_ms - arm_time_in) >= cfg.arm_delay_ms);

      under     = $signed(CMP_W'(sum)) < $signed(CMP_W'(cfg.min_thrust));
      since_eff = bad_valid_ff ? bad_since_ff : now_ms;

      if (is_check && result.active) begin
         if (under) begin
            result.under_thrust = 1'b1;
            bad_valid_in        = 1'b1;
            bad_since_in        = since_eff;
            result.abort        = (now_ms - since_eff) > cfg.abort_time_ms;
         end else begin
            bad_valid_in = 1'b0;
            bad_since_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         baseline_ff  <= '0;
         armed_ff     <= 1'b0;
         arm_time_ff  <= '0;
         bad_valid_ff <= 1'b0;
         bad_since_ff <= '0;
      end else if (step) begin
         baseline_ff  <= baseline_in;
         armed_ff     <= armed_in;
         arm_time_ff  <= arm_time_in;
         bad_valid_ff <= bad_valid_in;
         bad_since_ff <= bad_since_in;
      end
   end

endmodule

@@ sv/load_cell_underthrust_abort.sv @@
// Top level of the load-cell under-thrust abort monitor.
// Depends on lcua_pkg, lcua_csr and lcua_mon.
//
// Request words carry a kind in req_tuser (check, flow start, stop) and the
// time stamp, four signed load readings and the hotfire flag in req_tdata.
// Every request word yields exactly one response word with the abort, active
// and under_thrust flags. A hotfire flow start latches the readings as
// baselines and arms the monitor; checks are evaluated once the arm delay
// has passed, and a stop disarms it.
// The accepted word sits in the input register while the decision logic
// feeds the response register that drives the response word.
// Throughput is one word per cycle while the receiver keeps taking
// responses; the channel adder and compares that update the monitor
// state are combinational.
// A full response register that the receiver stalls holds its word; the
// input register keeps taking one more word, then req_tready drops until
// the response is taken.
// Reset clears the baselines, arm and persistence state and loads the
// default threshold, abort time and arm delay. Write csr_* only while idle.
module load_cell_underthrust_abort #(
   parameter int CHANNELS = lcua_pkg::CHANNELS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // [1:0] kind
   input  logic [lcua_pkg::KIND_W-1:0]         req_tuser,
   // [31:0] now_ms, [55:32] load_a, [79:56] load_b, [103:80] load_c,
   // [127:104] load_d, [128] hotfire, rest zero
   input  logic [lcua_pkg::REQ_DATA_W-1:0]     req_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // [0] abort, [1] active, [2] under_thrust, rest zero
   output logic [lcua_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   input  logic                                csr_we,
   input  logic [lcua_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [lcua_pkg::CSR_W-1:0]          csr_wdata
);

   localparam int HOT_BIT = lcua_pkg::TIME_W + lcua_pkg::IN_CH * lcua_pkg::LOAD_W;

   logic                                           in_valid_ff;
   logic [lcua_pkg::KIND_W-1:0]                    in_kind_ff;
   logic [lcua_pkg::TIME_W-1:0]                    in_now_ff;
   logic [lcua_pkg::IN_CH-1:0][lcua_pkg::LOAD_W-1:0] in_loads_ff;
   logic                                           in_hot_ff;
   logic                                           out_valid_ff, out_valid_in;
   lcua_pkg::result_type                           out_res_ff;
   lcua_pkg::result_type                           result;
   lcua_pkg::cfg_type                              cfg;
   logic [CHANNELS-1:0][lcua_pkg::LOAD_W-1:0]      load_arr;
   logic                                           step;
   logic                                           req_take;

   assign step       = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || step;
   assign req_take   = req_tvalid && req_tready;

   for (genvar ch = 0; ch < CHANNELS; ch++) begin : g_load
      if (ch < lcua_pkg::IN_CH) begin : g_live
         assign load_arr[ch] = in_loads_ff[ch];
      end else begin : g_zero
         assign load_arr[ch] = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_kind_ff  <= req_tuser;
         in_now_ff   <= req_tdata[lcua_pkg::TIME_W-1:0];
         in_loads_ff <= req_tdata[HOT_BIT-1:lcua_pkg::TIME_W];
         in_hot_ff   <= req_tdata[HOT_BIT];
      end
   end

   lcua_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   lcua_mon #(
      .CHANNELS (CHANNELS)
   ) u_mon (
      .clock   (clock),
      .reset   (reset),
      .step    (step),
      .kind    (in_kind_ff),
      .now_ms  (in_now_ff),
      .loads   (load_arr),
      .hotfire (in_hot_ff),
      .cfg     (cfg),
      .result  (result)
   );

   always_comb begin
      out_valid_in = out_valid_ff;
      if (step) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         out_res_ff <= result;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{(lcua_pkg::RSP_DATA_W - 3){1'b0}},
                        out_res_ff.under_thrust, out_res_ff.active, out_res_ff.abort};

endmodule
